>>> rtl/gng_pkg.sv
// ----------------------------------------------------------------------------
// gng_pkg
// shared types and constants for the polar-method gaussian generator
// ----------------------------------------------------------------------------
package gng_pkg;

    // output fixed point
    localparam int FRAC_BITS = 12;
    localparam int X_SHL     = (2 * FRAC_BITS >= 26) ? (2 * FRAC_BITS - 26) : 0;
    localparam int X_SHR     = (2 * FRAC_BITS >= 26) ? 0 : (26 - 2 * FRAC_BITS);

    // generator and method constants
    localparam logic [31:0] LCG_MUL = 32'd1103515245;
    localparam logic [31:0] LCG_ADD = 32'd12345;
    localparam logic [29:0] K_SQ    = 30'd1073676289;   // 32767 squared
    localparam logic [31:0] LN2_Q29 = 32'd372130559;
    localparam logic [31:0] SEED_RST = 32'd1;

    // iterative divide / root unit
    localparam logic [5:0] DIV_LAST  = 6'd61;
    localparam logic [5:0] SQRT_LAST = 6'd15;
    localparam logic [4:0] LOG_LAST  = 5'd29;

    typedef enum logic [0:0] {
        RD_DIV,
        RD_SQRT
    } rd_op_t;

    typedef struct packed {
        logic   start;
        rd_op_t op;
    } rd_req_t;

    typedef struct packed {
        logic        done;
        logic [31:0] value;
        logic        round_up;
    } rd_rsp_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DRAW_A,
        ST_DRAW_B,
        ST_SQ_A,
        ST_SQ_B,
        ST_CHECK,
        ST_NORM,
        ST_LOG,
        ST_DIFF,
        ST_LN_LO,
        ST_LN_HI,
        ST_MUL_X,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_SQ_GO,
        ST_SQ_WAIT,
        ST_DONE
    } gng_state_t;

endpackage

>>> rtl/gng_root_div.sv
// ----------------------------------------------------------------------------
// gng_root_div
// restoring divider and digit-by-digit square root on one shared subtractor
// ----------------------------------------------------------------------------
module gng_root_div
    import gng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  rd_req_t     req,
    input  logic [61:0] num,    // dividend, or radicand in the low 32 bits
    input  logic [29:0] den,
    output rd_rsp_t     rsp
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    rd_op_t      op_reg, op_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic [61:0] acc_reg, acc_next;   // quotient, or root
    logic [32:0] rem_reg, rem_next;   // remainder
    logic [30:0] bit_reg, bit_next;

    logic [32:0] sub_a;
    logic [32:0] sub_b;
    logic [33:0] diff;
    logic        ge;

    always_comb
    begin
        if (op_reg == RD_DIV)
        begin
            sub_a = {2'b00, rem_reg[29:0], acc_reg[61]};
            sub_b = {3'b000, den};
        end
        else
        begin
            sub_a = rem_reg;
            sub_b = acc_reg[32:0] + {2'b00, bit_reg};
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = ~diff[33];
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        rem_next  = rem_reg;
        bit_next  = bit_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            bit_next  = 31'h4000_0000;
            if (req.op == RD_DIV)
            begin
                acc_next = num;
                rem_next = '0;
            end
            else
            begin
                acc_next = '0;
                rem_next = {1'b0, num[31:0]};
            end
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + 6'd1;
            if (op_reg == RD_DIV)
            begin
                acc_next = {acc_reg[60:0], ge};
                rem_next = ge ? diff[32:0] : sub_a;
                if (cnt_reg == DIV_LAST)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
            else
            begin
                if (ge)
                begin
                    rem_next = diff[32:0];
                    acc_next = {1'b0, acc_reg[61:1]} + {31'd0, bit_reg};
                end
                else
                begin
                    acc_next = {1'b0, acc_reg[61:1]};
                end
                bit_next = {2'b00, bit_reg[30:2]};
                if (cnt_reg == SQRT_LAST)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            op_reg   <= RD_DIV;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        rem_reg <= rem_next;
        bit_reg <= bit_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.value    = acc_reg[31:0];
    assign rsp.round_up = (rem_reg > {1'b0, acc_reg[31:0]});

endmodule

>>> rtl/gaussian_noise_generator_core.sv
// ----------------------------------------------------------------------------
// gaussian_noise_generator_core
// normal samples by the polar rejection method fed from a 32-bit lcg
// ----------------------------------------------------------------------------
//  channel   dir  fields (lsb up)                  handshake
//  s_*       in   tdata[0] restart, rest zero      tvalid / tready
//  m_*       out  tdata sample, tuser from_spare   tvalid / tready
//  seed_*    in   seed_wdata seed                  seed_we, no wait
//
//  a beat with a spare held is answered from the spare; otherwise a pair is
//  drawn and redrawn on each rejection, and the work is set by the 30-step
//  log loop run twice and two 62-step divides and 16-step roots
//  s_tready is high only while the sequencer is idle
//  a result waits in the output register; the next beat is taken meanwhile
//  asynchronous active-low reset: seed 1, lcg 1, no spare
// ----------------------------------------------------------------------------
module gaussian_noise_generator_core
    import gng_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        seed_we,
    input  logic [31:0] seed_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [0] restart, [7:1] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,    // [15:0] sample
    output logic        m_tuser     // [0] from_spare
);

    // sequencer
    gng_state_t state_reg, state_next;

    // configuration and architectural state
    logic [31:0] seed_reg;
    logic [31:0] lcg_reg;
    logic        spare_valid_reg;
    logic [15:0] spare_reg;

    // working registers
    logic [15:0] a_reg, b_reg;          // signed uniforms
    logic [29:0] a2_reg, b2_reg;
    logic [29:0] m_reg;
    logic [30:0] y_reg;                 // log mantissa
    logic [4:0]  e_reg;
    logic [28:0] frac_reg;
    logic [4:0]  cnt_reg;
    logic        pass_reg;              // 0: log of k squared, 1: log of m
    logic [34:0] lk_reg, la_reg, d_reg;
    logic [63:0] acc_reg;
    logic [30:0] t26_reg;
    logic [61:0] n_reg;
    logic [31:0] x_reg;
    logic        sel_reg;               // 0: working on a, 1: on b
    logic [15:0] res_sample_reg;
    logic        res_spare_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] out_sample_reg;
    logic        out_spare_reg;

    // shared multiplier
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    // divider / root
    rd_req_t     rd_req;
    rd_rsp_t     rd_rsp;

    logic        in_beat;
    logic        out_free;
    logic [31:0] lcg_new;
    logic [15:0] uni;
    logic [30:0] msum;
    logic        reject;
    logic [31:0] ysq;
    logic [63:0] ln_sum;
    logic [15:0] c_sel;
    logic [16:0] mag;
    logic [15:0] signed_out;
    logic [31:0] x_scaled;

    assign in_beat  = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // one multiplier serves the lcg, the squares, the log loop, the ln 2 product and the scaling
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            ST_DRAW_A, ST_DRAW_B:
            begin
                mul_a = lcg_reg;
                mul_b = LCG_MUL;
            end
            ST_SQ_A:
            begin
                mul_a = {16'd0, a_reg[15] ? (16'd0 - a_reg) : a_reg};
                mul_b = mul_a;
            end
            ST_SQ_B:
            begin
                mul_a = {16'd0, b_reg[15] ? (16'd0 - b_reg) : b_reg};
                mul_b = mul_a;
            end
            ST_LOG:
            begin
                mul_a = {1'b0, y_reg};
                mul_b = {1'b0, y_reg};
            end
            ST_LN_LO:
            begin
                mul_a = {14'd0, d_reg[17:0]};
                mul_b = LN2_Q29;
            end
            ST_LN_HI:
            begin
                mul_a = {15'd0, d_reg[34:18]};
                mul_b = LN2_Q29;
            end
            ST_MUL_X:
            begin
                mul_a = {2'b00, sel_reg ? b2_reg : a2_reg};
                mul_b = {1'b0, t26_reg};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    // lcg step and the odd uniform 2r - 32767
    assign lcg_new = mul_p[31:0] + LCG_ADD;
    assign uni     = {~lcg_new[30], lcg_new[29:16], 1'b1};

    assign msum   = {1'b0, a2_reg} + {1'b0, b2_reg};
    assign reject = (msum == '0) || (msum >= {1'b0, K_SQ});

    assign ysq    = mul_p[61:30];
    assign ln_sum = acc_reg + {mul_p[45:0], 18'd0};

    // sign, round and saturate the root
    assign c_sel = sel_reg ? b_reg : a_reg;
    assign mag   = rd_rsp.value[16:0] + {16'd0, rd_rsp.round_up};
    always_comb
    begin
        if (c_sel[15])
        begin
            signed_out = (mag > 17'd32768) ? 16'h8000 : (16'd0 - mag[15:0]);
        end
        else
        begin
            signed_out = (mag > 17'd32767) ? 16'h7FFF : mag[15:0];
        end
    end

    assign x_scaled = (rd_rsp.value << X_SHL) >> X_SHR;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    state_next = spare_valid_reg ? ST_DONE : ST_DRAW_A;
                end
            end
            ST_DRAW_A:   state_next = ST_DRAW_B;
            ST_DRAW_B:   state_next = ST_SQ_A;
            ST_SQ_A:     state_next = ST_SQ_B;
            ST_SQ_B:     state_next = ST_CHECK;
            ST_CHECK:    state_next = reject ? ST_DRAW_A : ST_NORM;
            ST_NORM:     state_next = y_reg[30] ? ST_LOG : ST_NORM;
            ST_LOG:
            begin
                if (cnt_reg == LOG_LAST)
                begin
                    state_next = pass_reg ? ST_DIFF : ST_NORM;
                end
            end
            ST_DIFF:     state_next = ST_LN_LO;
            ST_LN_LO:    state_next = ST_LN_HI;
            ST_LN_HI:    state_next = ST_MUL_X;
            ST_MUL_X:    state_next = ST_DIV_GO;
            ST_DIV_GO:   state_next = ST_DIV_WAIT;
            ST_DIV_WAIT: state_next = rd_rsp.done ? ST_SQ_GO : ST_DIV_WAIT;
            ST_SQ_GO:    state_next = ST_SQ_WAIT;
            ST_SQ_WAIT:
            begin
                if (rd_rsp.done)
                begin
                    state_next = sel_reg ? ST_DONE : ST_MUL_X;
                end
            end
            ST_DONE:     state_next = out_free ? ST_IDLE : ST_DONE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready     = 1'b0;
        rd_req.start = 1'b0;
        rd_req.op    = RD_DIV;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
            end
            ST_DIV_GO:
            begin
                rd_req.start = 1'b1;
                rd_req.op    = RD_DIV;
            end
            ST_SQ_GO:
            begin
                rd_req.start = 1'b1;
                rd_req.op    = RD_SQRT;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    gng_root_div u_root_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rd_req),
        .num   (ST_SQ_GO == state_reg ? {30'd0, x_reg} : n_reg),
        .den   (m_reg),
        .rsp   (rd_rsp)
    );

    // control and architectural state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            seed_reg        <= SEED_RST;
            lcg_reg         <= SEED_RST;
            spare_valid_reg <= 1'b0;
            spare_reg       <= '0;
            out_valid_reg   <= 1'b0;
            cnt_reg         <= '0;
            pass_reg        <= 1'b0;
            sel_reg         <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (seed_we)
            begin
                seed_reg <= seed_wdata;
            end

            if (in_beat && s_tdata[0])
            begin
                lcg_reg <= seed_reg;
            end
            else if (state_reg == ST_DRAW_A || state_reg == ST_DRAW_B)
            begin
                lcg_reg <= lcg_new;
            end

            if (in_beat && spare_valid_reg)
            begin
                spare_valid_reg <= 1'b0;
            end
            else if (state_reg == ST_SQ_WAIT && rd_rsp.done && sel_reg)
            begin
                spare_valid_reg <= 1'b1;
                spare_reg       <= signed_out;
            end

            // log loop bookkeeping
            if (state_reg == ST_CHECK)
            begin
                pass_reg <= 1'b0;
                sel_reg  <= 1'b0;
            end
            else if (state_reg == ST_NORM)
            begin
                cnt_reg <= '0;
            end
            else if (state_reg == ST_LOG)
            begin
                cnt_reg <= cnt_reg + 5'd1;
                if (cnt_reg == LOG_LAST)
                begin
                    pass_reg <= 1'b1;
                end
            end
            else if (state_reg == ST_SQ_WAIT && rd_rsp.done)
            begin
                sel_reg <= 1'b1;
            end

            if (state_reg == ST_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_beat)
                begin
                    res_sample_reg <= spare_reg;
                    res_spare_reg  <= spare_valid_reg;
                end
            end
            ST_DRAW_A: a_reg  <= uni;
            ST_DRAW_B: b_reg  <= uni;
            ST_SQ_A:   a2_reg <= mul_p[29:0];
            ST_SQ_B:   b2_reg <= mul_p[29:0];
            ST_CHECK:
            begin
                m_reg <= msum[29:0];
                y_reg <= {1'b0, K_SQ};
                e_reg <= 5'd30;
            end
            ST_NORM:
            begin
                frac_reg <= '0;
                if (!y_reg[30])
                begin
                    y_reg <= {y_reg[29:0], 1'b0};
                    e_reg <= e_reg - 5'd1;
                end
            end
            ST_LOG:
            begin
                // square, and take a fraction bit when it reaches two
                frac_reg <= {frac_reg[27:0], ysq[31]};
                if (cnt_reg == LOG_LAST && !pass_reg)
                begin
                    // k squared done, load m for the second pass
                    lk_reg <= {e_reg, frac_reg, ysq[31]};
                    y_reg  <= {1'b0, m_reg};
                    e_reg  <= 5'd30;
                end
                else
                begin
                    y_reg <= ysq[31] ? ysq[31:1] : ysq[30:0];
                    if (cnt_reg == LOG_LAST)
                    begin
                        la_reg <= {e_reg, frac_reg, ysq[31]};
                    end
                end
            end
            ST_DIFF:  d_reg <= (lk_reg > la_reg) ? (lk_reg - la_reg) : '0;
            ST_LN_LO: acc_reg <= mul_p;
            ST_LN_HI: t26_reg <= ln_sum[63:33];
            ST_MUL_X: n_reg <= {mul_p[60:0], 1'b0};
            ST_DIV_WAIT:
            begin
                if (rd_rsp.done)
                begin
                    x_reg <= x_scaled;
                end
            end
            ST_SQ_WAIT:
            begin
                if (rd_rsp.done && !sel_reg)
                begin
                    res_sample_reg <= signed_out;
                    res_spare_reg  <= 1'b0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_sample_reg <= res_sample_reg;
                    out_spare_reg  <= res_spare_reg;
                end
            end
            default:
            begin
                acc_reg <= acc_reg;
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_sample_reg;
    assign m_tuser  = out_spare_reg;

endmodule

>>> rtl/gng_checker.sv
// ----------------------------------------------------------------------------
// gng_port_checker
// port-level checks on the gaussian generator, bound to the top level
// ----------------------------------------------------------------------------
module gng_port_checker
    import gng_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    // the sequencer leaves idle after every input beat
    a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken on consecutive cycles");

    // a result held back keeps its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // a new result only appears after the sequencer was busy
    a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("output beat without work");

endmodule

bind gaussian_noise_generator_core gng_port_checker u_gng_port_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
